// ===== rtl/mpsm_pkg.sv =====
// Shared types and codes for the multi-pattern stream matcher.
package mpsm_pkg;

    localparam int OP_W  = 2;
    localparam int SYM_W = 8;

    localparam logic [OP_W-1:0] OP_PAT_SYM = 2'd0;
    localparam logic [OP_W-1:0] OP_PAT_END = 2'd1;
    localparam logic [OP_W-1:0] OP_BUILD   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAT_RD,
        ST_PAT_EV,
        ST_END_WR,
        ST_QRY_RD,
        ST_QRY_EV,
        ST_QRY_ACC,
        ST_BLD_CRD,
        ST_BLD_CEV,
        ST_BLD_FRD,
        ST_BLD_FEV,
        ST_BLD_AEV,
        ST_BLD_POP,
        ST_BLD_QWT,
        ST_OUT
    } mpsm_state_t;

endpackage

// ===== rtl/multi_pattern_stream_matcher.sv =====
// Top level of the multi-pattern stream matcher (Aho-Corasick automaton).
//
// Multi-pattern byte matcher. Each input beat carries an operation in s_tuser
// and a symbol in s_tdata: load a pattern symbol, end a pattern, build the
// failure links, or run one stream symbol through the automaton. Every beat
// returns exactly one result beat with a match flag and a table-full flag.
// Symbols are reduced modulo ALPHABET_SIZE. All state lives in RAMs with
// registered read data: a child table of MAX_NODES*ALPHABET_SIZE entries,
// failure links, accepting flags and a BFS queue, walked by one sequencer
// that handles one beat at a time. A query follows failure links until a
// child exists or the root is reached. A build visits every node and every
// symbol, follows failure links for each child below the root and takes
// each node from the queue in BFS order. After reset a clearing pass writes
// every entry of the child table, during which s_tready stays low. A new
// beat is taken while the previous result still waits on the master side.
module multi_pattern_stream_matcher
    import mpsm_pkg::*;
#(
    parameter int MAX_NODES     = 256,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] status, [7:2] zero
);

    localparam int NW       = $clog2(MAX_NODES);
    localparam int CW       = $clog2(MAX_NODES + 1);
    localparam int SW       = $clog2(ALPHABET_SIZE);
    localparam int CT_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int CAW      = $clog2(CT_DEPTH);

    // symbol modulo alphabet, worked out at elaboration
    logic [SW-1:0] sym_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_sym_tab
        assign sym_tab[g] = SW'(g % ALPHABET_SIZE);
    end

    function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] node,
                                             input logic [SW-1:0] sym);
        return CAW'(32'(node) * 32'(ALPHABET_SIZE) + 32'(sym));
    endfunction

    mpsm_state_t state_reg, state_next;
    logic [SW-1:0]  sym_reg, sym_next;
    logic [NW-1:0]  cursor_reg, cursor_next;
    logic [NW-1:0]  mstate_reg, mstate_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [NW-1:0]  qn_reg, qn_next;
    logic [NW-1:0]  u_reg, u_next;
    logic [NW-1:0]  v_reg, v_next;
    logic [NW-1:0]  f_reg, f_next;
    logic [SW-1:0]  bs_reg, bs_next;
    logic           root_reg, root_next;
    logic [CW-1:0]  head_reg, head_next;
    logic [CW-1:0]  tail_reg, tail_next;
    logic [CAW-1:0] clr_reg, clr_next;
    logic           res_match_reg, res_match_next;
    logic           res_stat_reg, res_stat_next;
    logic           m_valid_reg, m_valid_next;
    logic [1:0]     m_data_reg, m_data_next;

    // RAM ports
    logic           ct_we;
    logic [CAW-1:0] ct_waddr, ct_raddr;
    logic [NW-1:0]  ct_wdata, ct_rdata;
    logic [NW-1:0]  ct_rnode;
    logic           fl_we;
    logic [NW-1:0]  fl_waddr, fl_wdata, fl_raddr, fl_rdata;
    logic           ac_we;
    logic [NW-1:0]  ac_waddr, ac_raddr;
    logic           ac_wdata, ac_rdata;
    logic           qu_we;
    logic [NW-1:0]  qu_waddr, qu_wdata, qu_raddr, qu_rdata;

    logic           s_fire;
    logic           out_free;
    logic           bs_last;
    logic           room;
    logic [NW-1:0]  fv_c;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign bs_last  = (bs_reg == SW'(ALPHABET_SIZE - 1));
    assign room     = (count_reg < CW'(MAX_NODES));
    // failure target of the child; a self link means root
    assign fv_c     = (ct_rdata == v_reg) ? '0 : ct_rdata;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    // next state and register updates
    always_comb begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        cursor_next    = cursor_reg;
        mstate_next    = mstate_reg;
        count_next     = count_reg;
        qn_next        = qn_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        f_next         = f_reg;
        bs_next        = bs_reg;
        root_next      = root_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        clr_next       = clr_reg;
        res_match_next = res_match_reg;
        res_stat_next  = res_stat_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CAW'(CT_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    sym_next       = sym_tab[s_tdata];
                    res_match_next = 1'b0;
                    res_stat_next  = 1'b0;
                    qn_next        = mstate_reg;
                    unique case (s_tuser)
                        OP_PAT_SYM: state_next = ST_PAT_RD;
                        OP_PAT_END: state_next = ST_END_WR;
                        OP_BUILD: begin
                            u_next     = '0;
                            root_next  = 1'b1;
                            bs_next    = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = ST_BLD_CRD;
                        end
                        OP_QUERY:   state_next = ST_QRY_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PAT_RD: state_next = ST_PAT_EV;
            ST_PAT_EV: begin
                if (ct_rdata != '0) begin
                    cursor_next = ct_rdata;
                end else if (!room) begin
                    res_stat_next = 1'b1;
                end else begin
                    cursor_next = NW'(count_reg);
                    count_next  = count_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_END_WR: begin
                cursor_next = '0;
                state_next  = ST_OUT;
            end
            ST_QRY_RD: state_next = ST_QRY_EV;
            ST_QRY_EV: begin
                if (ct_rdata != '0 || qn_reg == '0) begin
                    qn_next    = ct_rdata;
                    state_next = ST_QRY_ACC;
                end else begin
                    qn_next    = fl_rdata;
                    state_next = ST_QRY_RD;
                end
            end
            ST_QRY_ACC: begin
                res_match_next = ac_rdata;
                mstate_next    = qn_reg;
                state_next     = ST_OUT;
            end
            ST_BLD_CRD: state_next = ST_BLD_CEV;
            ST_BLD_CEV: begin
                if (ct_rdata == '0 || root_reg) begin
                    if (ct_rdata != '0 && tail_reg < CW'(MAX_NODES)) begin
                        tail_next = tail_reg + 1'b1;
                    end
                    bs_next    = bs_reg + 1'b1;
                    state_next = bs_last ? ST_BLD_POP : ST_BLD_CRD;
                end else begin
                    if (tail_reg < CW'(MAX_NODES)) begin
                        tail_next = tail_reg + 1'b1;
                    end
                    v_next     = ct_rdata;
                    f_next     = fl_rdata;
                    state_next = ST_BLD_FRD;
                end
            end
            ST_BLD_FRD: state_next = ST_BLD_FEV;
            ST_BLD_FEV: begin
                if (f_reg != '0 && ct_rdata == '0) begin
                    f_next     = fl_rdata;
                    state_next = ST_BLD_FRD;
                end else begin
                    state_next = ST_BLD_AEV;
                end
            end
            ST_BLD_AEV: begin
                bs_next    = bs_reg + 1'b1;
                state_next = bs_last ? ST_BLD_POP : ST_BLD_CRD;
            end
            ST_BLD_POP: begin
                state_next = (head_reg == tail_reg) ? ST_OUT : ST_BLD_QWT;
            end
            ST_BLD_QWT: begin
                u_next     = qu_rdata;
                head_next  = head_reg + 1'b1;
                root_next  = 1'b0;
                bs_next    = '0;
                state_next = ST_BLD_CRD;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_stat_reg, res_match_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        ct_we    = 1'b0;
        ct_waddr = caddr(cursor_reg, sym_reg);
        ct_wdata = NW'(count_reg);
        ct_rnode = cursor_reg;
        fl_we    = 1'b0;
        fl_waddr = v_reg;
        fl_wdata = fv_c;
        fl_raddr = u_reg;
        ac_we    = 1'b0;
        ac_waddr = cursor_reg;
        ac_wdata = 1'b1;
        ac_raddr = fv_c;
        qu_we    = 1'b0;
        qu_waddr = tail_reg[NW-1:0];
        qu_wdata = ct_rdata;
        qu_raddr = head_reg[NW-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                ct_we    = 1'b1;
                ct_waddr = clr_reg;
                ct_wdata = '0;
                fl_we    = (clr_reg < CAW'(MAX_NODES));
                fl_waddr = clr_reg[NW-1:0];
                fl_wdata = '0;
                ac_we    = (clr_reg < CAW'(MAX_NODES));
                ac_waddr = clr_reg[NW-1:0];
                ac_wdata = 1'b0;
            end
            ST_PAT_EV: begin
                ct_we = (ct_rdata == '0) && room;
            end
            ST_END_WR: begin
                ac_we = 1'b1;
            end
            ST_QRY_RD: begin
                ct_rnode = qn_reg;
                fl_raddr = qn_reg;
            end
            ST_QRY_EV: begin
                ac_raddr = ct_rdata;
            end
            ST_BLD_CRD: begin
                ct_rnode = u_reg;
                fl_raddr = u_reg;
            end
            ST_BLD_CEV: begin
                // enqueue every child; root children get a link to root
                qu_we    = (ct_rdata != '0) && (tail_reg < CW'(MAX_NODES));
                fl_we    = (ct_rdata != '0) && root_reg;
                fl_waddr = ct_rdata;
                fl_wdata = '0;
            end
            ST_BLD_FRD: begin
                ct_rnode = f_reg;
                fl_raddr = f_reg;
            end
            ST_BLD_FEV: begin
                fl_we = (f_reg == '0) || (ct_rdata != '0);
            end
            ST_BLD_AEV: begin
                // inherit accepting flag from the failure target
                ac_we    = ac_rdata;
                ac_waddr = v_reg;
            end
            default: begin
                ct_we = 1'b0;
            end
        endcase
    end

    assign ct_raddr = caddr(ct_rnode, (state_reg == ST_BLD_CRD || state_reg == ST_BLD_FRD)
                                      ? bs_reg : sym_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cursor_reg  <= '0;
            mstate_reg  <= '0;
            count_reg   <= CW'(1);
            root_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            mstate_reg  <= mstate_next;
            count_reg   <= count_next;
            root_reg    <= root_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg       <= sym_next;
        qn_reg        <= qn_next;
        u_reg         <= u_next;
        v_reg         <= v_next;
        f_reg         <= f_next;
        bs_reg        <= bs_next;
        res_match_reg <= res_match_next;
        res_stat_reg  <= res_stat_next;
        m_data_reg    <= m_data_next;
    end

    mpsm_ram #(.WIDTH(NW), .DEPTH(CT_DEPTH)) u_child (
        .aclk  (aclk),
        .we    (ct_we),
        .waddr (ct_waddr),
        .wdata (ct_wdata),
        .raddr (ct_raddr),
        .rdata (ct_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    mpsm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_acc (
        .aclk  (aclk),
        .we    (ac_we),
        .waddr (ac_waddr),
        .wdata (ac_wdata),
        .raddr (ac_raddr),
        .rdata (ac_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .aclk  (aclk),
        .we    (qu_we),
        .waddr (qu_waddr),
        .wdata (qu_wdata),
        .raddr (qu_raddr),
        .rdata (qu_rdata)
    );

    // node allocation never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_NODES))
        else $error("node count beyond table size");

    // insertion cursor always names an allocated node
    a_cursor_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(cursor_reg) < count_reg)
        else $error("insert cursor on unallocated node");

    // match state always names an allocated node
    a_match_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(mstate_reg) < count_reg)
        else $error("match state on unallocated node");

    // the BFS queue never holds more nodes than exist
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg <= count_reg) && (head_reg <= tail_reg))
        else $error("BFS queue pointers out of range");

endmodule

// ===== rtl/mpsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
